// ===== rtl/blocked_bloom_filter_defines.svh =====
// Assertion helpers for the RTL of the blocked Bloom filter.
`ifndef BLOCKED_BLOOM_FILTER_DEFINES_SVH
`define BLOCKED_BLOOM_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bbf_pkg.sv =====
package bbf_pkg;

    // Field widths
    localparam int ACTION_W    = 2;
    localparam int HASH_W      = 64;
    localparam int PIDX_W      = 16;
    localparam int WORD_W      = 64;
    localparam int CFG_W       = 17;
    localparam int S_TDATA_W   = 144;
    localparam int M_TDATA_W   = 8;

    // Word count after reset
    localparam int WORDS_RESET = 65536;

    // Action codes carried in tuser
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_APPLY
    } bbf_state_t;

    // Status of the serial remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } bbf_div_stat_t;

endpackage

// ===== rtl/blocked_bloom_filter.sv =====
// Blocked Bloom filter, inverted polarity: an insert clears bits, a query
// reports present when all pattern bits are clear in the selected word.
// Input stream (s_*): tuser holds the action (0 insert, 1 query, 2 load
// pattern); tdata holds hash, pattern_index and pattern_word. Output stream
// (m_*): one transfer per query, tdata bit 0 is the present flag.
// Configuration channel (cfg_*): word count, always ready; write it only
// while the block is idle. 0 reads as 1, values above BITMAP_DEPTH saturate.
// A load or an unused action is handled on accept, and the block stays idle.
// Insert and query form the word address as the bit-serial remainder of the
// hash bits above the pattern index, then do a registered bitmap read, then
// the write or the result, with s_tready low until they are done.
// After reset the bitmap is swept to all ones, one word per cycle, with
// s_tready low. The result sits in an output register, so the next item is
// taken while it waits; a query that finishes while an earlier result is
// still stalled holds until m_tready.
`include "blocked_bloom_filter_defines.svh"

module blocked_bloom_filter
    import bbf_pkg::*;
#(
    parameter int PATTERN_INDEX_BITS = 16,
    parameter int BITMAP_DEPTH       = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // hash [63:0], pattern_index [79:64], pattern_word [143:80]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action [1:0]
    input  logic [ACTION_W-1:0]  s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // present [0], zeros above
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int P         = PATTERN_INDEX_BITS;
    localparam int PAT_DEPTH = 1 << P;
    localparam int DW        = HASH_W - P;
    localparam int AW        = (BITMAP_DEPTH > 1) ? $clog2(BITMAP_DEPTH) : 1;
    localparam int NW        = $clog2(BITMAP_DEPTH + 1);
    localparam int CMP_W     = (NW > CFG_W) ? NW : CFG_W;
    localparam logic [NW-1:0] WORDS_RST =
        (WORDS_RESET > BITMAP_DEPTH) ? NW'(BITMAP_DEPTH) : NW'(WORDS_RESET);

    bbf_state_t     state_reg, state_next;
    logic [NW-1:0]  words_reg, words_next;
    logic [CMP_W-1:0] cfg_ext;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic           m_valid_reg, m_valid_next;
    logic           present_reg, present_next;
    logic [ACTION_W-1:0] act_reg;
    logic [WORD_W-1:0]   pat_reg;
    logic [WORD_W-1:0]   bm_rd_reg;
    logic [WORD_W-1:0]   pattern_mem [PAT_DEPTH];
    logic [WORD_W-1:0]   bitmap_mem [BITMAP_DEPTH];

    logic           s_accept;
    logic           is_lookup;
    logic           div_start;
    logic [AW-1:0]  div_rem;
    bbf_div_stat_t  div_stat;
    logic           clr_last;
    logic           bm_we;
    logic [AW-1:0]  bm_waddr;
    logic [WORD_W-1:0] bm_wdata;
    logic           res_load;

    assign s_accept  = s_tvalid && s_tready;
    assign is_lookup = (s_tuser == ACT_INSERT) || (s_tuser == ACT_QUERY);
    assign clr_last  = (clr_cnt_reg == AW'(BITMAP_DEPTH - 1));
    assign cfg_ready = 1'b1;

    // Word count register, clamped on write
    always_comb
    begin
        cfg_ext    = CMP_W'(cfg_data);
        words_next = words_reg;
        if (cfg_valid)
        begin
            if (cfg_ext == '0)
                words_next = NW'(1);
            else if (cfg_ext > CMP_W'(BITMAP_DEPTH))
                words_next = NW'(BITMAP_DEPTH);
            else
                words_next = NW'(cfg_ext);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_accept && is_lookup)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_APPLY;
            ST_APPLY:
                if (act_reg != ACT_QUERY || !m_valid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        bm_we        = 1'b0;
        bm_waddr     = div_rem;
        bm_wdata     = bm_rd_reg & ~pat_reg;
        res_load     = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                bm_we        = 1'b1;
                bm_waddr     = clr_cnt_reg;
                bm_wdata     = '1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid && is_lookup;
            end
            ST_DIV:
            begin
            end
            ST_APPLY:
            begin
                bm_we    = (act_reg == ACT_INSERT);
                res_load = (act_reg == ACT_QUERY) && (!m_valid_reg || m_tready);
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        present_next = present_reg;
        if (res_load)
        begin
            m_valid_next = 1'b1;
            present_next = ((bm_rd_reg & pat_reg) == '0);
        end
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(present_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            words_reg   <= WORDS_RST;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            present_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            words_reg   <= words_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            present_reg <= present_next;
        end
    end

    // Pattern table: load on accept, read for insert and query
    always_ff @(posedge clk)
    begin
        if (s_accept && s_tuser == ACT_LOAD)
            pattern_mem[P'(s_tdata[HASH_W +: PIDX_W])] <= s_tdata[HASH_W + PIDX_W +: WORD_W];
        if (div_start)
        begin
            pat_reg <= pattern_mem[s_tdata[P-1:0]];
            act_reg <= s_tuser;
        end
    end

    // Bitmap: one write port, read at the remainder every cycle
    always_ff @(posedge clk)
    begin
        if (bm_we)
            bitmap_mem[bm_waddr] <= bm_wdata;
        bm_rd_reg <= bitmap_mem[div_rem];
    end

    bbf_mod_unit #(
        .DW (DW),
        .AW (AW),
        .NW (NW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_tdata[HASH_W-1:P]),
        .divisor  (words_reg),
        .rem      (div_rem),
        .stat     (div_stat)
    );

    `BBF_ASSERT_IMP(a_done_in_div, clk, rst_n, div_stat.done, state_reg == ST_DIV, "remainder done outside division state")
    `BBF_ASSERT_IMP(a_rem_range, clk, rst_n, div_stat.done, (AW + 1)'(div_rem) < (AW + 1)'(words_reg), "word address not below word count")
    `BBF_ASSERT_NXT(a_div_starts, clk, rst_n, div_start, div_stat.busy, "remainder unit did not start")
    `BBF_ASSERT_IMP(a_write_src, clk, rst_n, bm_we && state_reg != ST_CLEAR, act_reg == ACT_INSERT, "bitmap write without insert")
    `BBF_ASSERT_IMP(a_result_src, clk, rst_n, $rose(m_valid_reg), $past(state_reg) == ST_APPLY && act_reg == ACT_QUERY, "result without query")

endmodule

// ===== rtl/bbf_mod_unit.sv =====
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
module bbf_mod_unit
    import bbf_pkg::*;
#(
    parameter int DW = 48,
    parameter int AW = 16,
    parameter int NW = 17
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic [AW-1:0] rem,
    output bbf_div_stat_t stat
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic [NW-1:0] n_reg, n_next;
    logic [AW:0]   trial;
    logic [AW:0]   diff;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DW-1]};
        diff  = trial - (AW + 1)'(n_reg);
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        n_next    = n_reg;
        if (start)
        begin
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
            dvd_next  = dividend;
            rem_next  = '0;
            n_next    = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (trial >= (AW + 1)'(n_reg))
                rem_next = AW'(diff);
            else
                rem_next = AW'(trial);
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        n_reg   <= n_next;
    end

    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import bbf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DEPTH       = 65536;
    localparam int  TAIL_CYC    = 64;      // long enough for a trailing insert to finish
    localparam int  WD_LIMIT    = 300000;  // longer than the clearing sweep after reset
    localparam int  NUM_PHASES  = 10;
    localparam int  PER_PHASE   = 175;
    localparam int  MAX_REPORTS = 10;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // How a query row of the directed table is checked
    typedef enum logic [1:0] {
        ANS_MODEL,
        ANS_NO,
        ANS_YES
    } ans_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [HASH_W-1:0]   hash;
        logic [PIDX_W-1:0]   idx;
        logic [WORD_W-1:0]   word;
        ans_t                ans;
    } dir_row_t;

    // Directed part: extremes, zero pattern, overwrite of an entry, unused action
    localparam dir_row_t DIR_TAB [0:20] = '{
        '{ACT_LOAD,   64'h0,                   16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, ANS_MODEL},
        '{ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 64'h8000_0000_0000_0001, ANS_MODEL},
        '{ACT_LOAD,   64'h0,                   16'h5A5A, 64'h0,                   ANS_MODEL},
        '{ACT_LOAD,   64'h0,                   16'h00A5, 64'h0000_0000_0000_00F0, ANS_MODEL},
        '{ACT_QUERY,  64'h0,                   16'h0000, 64'h0,                   ANS_NO},
        '{ACT_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, ANS_NO},
        '{ACT_QUERY,  64'h1234_5678_9ABC_5A5A, 16'h0000, 64'h0,                   ANS_YES},
        '{ACT_INSERT, 64'h0,                   16'h0000, 64'h0,                   ANS_MODEL},
        '{ACT_QUERY,  64'h0,                   16'h0000, 64'h0,                   ANS_YES},
        '{ACT_QUERY,  64'h0000_0000_0001_0000, 16'h0000, 64'h0,                   ANS_NO},
        '{ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, ANS_MODEL},
        '{ACT_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 64'h0,                   ANS_YES},
        '{ACT_QUERY,  64'hFFFF_FFFF_FFFF_0000, 16'h0000, 64'h0,                   ANS_NO},
        '{ACT_UNUSED, 64'hDEAD_BEEF_0BAD_F00D, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, ANS_MODEL},
        '{ACT_INSERT, 64'h0000_0000_0002_00A5, 16'h0000, 64'h0,                   ANS_MODEL},
        '{ACT_QUERY,  64'h0000_0000_0002_0000, 16'h0000, 64'h0,                   ANS_NO},
        '{ACT_QUERY,  64'h0000_0000_0002_00A5, 16'h0000, 64'h0,                   ANS_YES},
        '{ACT_INSERT, 64'h0000_0000_0002_5A5A, 16'h0000, 64'h0,                   ANS_MODEL},
        '{ACT_QUERY,  64'h0000_0000_0003_5A5A, 16'h0000, 64'h0,                   ANS_YES},
        '{ACT_LOAD,   64'h0,                   16'h00A5, 64'hFFFF_FFFF_FFFF_FFFF, ANS_MODEL},
        '{ACT_QUERY,  64'h0000_0000_0002_00A5, 16'h0000, 64'h0,                   ANS_NO}
    };

    // Word counts, one per phase; the first is the reset value and is not written
    localparam int WORDS_PLAN [0:NUM_PHASES-1] =
        '{WORDS_RESET, 1, 0, 131071, 65537, 7, 1000, 65535, 3, 40000};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [ACTION_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Travels alongside each input transfer
    ans_t                 drv_ans   = ANS_MODEL;
    bit                   idling    = 1'b1;

    // Filter state as predicted
    bit [WORD_W-1:0]      bitmap_mem [int];
    bit [WORD_W-1:0]      pattern_mem [int];
    bit [CFG_W-1:0]       words_reg = CFG_W'(WORDS_RESET);

    // Presence flags still to come out of the block
    bit                   present_q [$];

    int                   err_cnt     = 0;
    int                   n_load      = 0;
    int                   n_insert    = 0;
    int                   n_query     = 0;
    int                   n_present   = 0;
    int                   n_checked   = 0;
    int                   quiet_cyc   = 0;

    blocked_bloom_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Apply one item to the predicted filter state
    task automatic bloom_step(input logic [ACTION_W-1:0] act, input logic [HASH_W-1:0] h,
                              input logic [PIDX_W-1:0] idx, input logic [WORD_W-1:0] w,
                              output bit has_res, output bit present);
        longint unsigned n;
        longint unsigned addr;
        bit [WORD_W-1:0] pat;
        bit [WORD_W-1:0] cur;
        has_res = 1'b0;
        present = 1'b0;
        if (act == ACT_LOAD)
            pattern_mem[int'(idx)] = w;
        else if (act == ACT_INSERT || act == ACT_QUERY)
        begin
            n = 64'(words_reg);
            if (n == 0)
                n = 1;
            if (n > DEPTH)
                n = DEPTH;
            addr = (longint'(h) >> PIDX_W) % n;
            pat  = pattern_mem.exists(int'(h[PIDX_W-1:0])) ? pattern_mem[int'(h[PIDX_W-1:0])]
                                                           : '0;
            cur  = bitmap_mem.exists(int'(addr)) ? bitmap_mem[int'(addr)] : '1;
            if (act == ACT_INSERT)
                bitmap_mem[int'(addr)] = cur & ~pat;
            else
            begin
                has_res = 1'b1;
                present = ((cur & pat) == '0);
            end
        end
    endtask

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("[%0t] error: %s", $realtime, msg);
    endtask

    // Watch all three channels: predict on input transfers, check output transfers
    always @(posedge clk)
    begin : watch
        bit has_res;
        bit pres;
        logic [M_TDATA_W-1:0] want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                words_reg = cfg_data;
            if (s_tvalid && s_tready)
            begin
                bloom_step(s_tuser, s_tdata[63:0], s_tdata[79:64], s_tdata[143:80],
                           has_res, pres);
                if (has_res)
                begin
                    if (drv_ans != ANS_MODEL)
                        pres = (drv_ans == ANS_YES);
                    present_q.push_back(pres);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (present_q.size() == 0)
                    note_error($sformatf("result with none expected, m_tdata 0x%02h", m_tdata));
                else
                begin
                    want = {{(M_TDATA_W-1){1'b0}}, present_q.pop_front()};
                    n_checked++;
                    if (want[0])
                        n_present++;
                    if (m_tdata !== want)
                        note_error($sformatf("present: expected 0x%02h, got 0x%02h",
                                             want, m_tdata));
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc == WD_LIMIT)
        begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WD_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Result back-pressure only when idling: mostly ready, short and rare long stalls
    always @(posedge clk)
    begin : rdy_gen
        int r;
        int hold;
        if (hold > 0)
            hold = hold - 1;
        else if (!idling)
            m_tready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                m_tready <= 1'b1;
                hold = $urandom_range(0, 20);
            end
            else if (r < 95)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(0, 3);
            end
            else
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(20, 80);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly a few scattered bits, sometimes dense, all ones or empty
    function automatic logic [WORD_W-1:0] rand_pattern();
        logic [WORD_W-1:0] p;
        int r;
        r = $urandom_range(0, 99);
        p = '0;
        if (r < 70)
            repeat ($urandom_range(1, 6))
                p[$urandom_range(0, WORD_W-1)] = 1'b1;
        else if (r < 90)
            p = rand64();
        else if (r < 95)
            p = '1;
        return p;
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [HASH_W-1:0] h,
                             input logic [PIDX_W-1:0] idx, input logic [WORD_W-1:0] w,
                             input ans_t ans);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {w, idx, h};
        drv_ans  <= ans;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Let the block drain: no results left, then time for a trailing insert
    task automatic settle();
        s_tvalid <= 1'b0;
        // the last transfer is booked by the monitor in this same time step
        @(posedge clk);
        while (present_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
    endtask

    task automatic write_words(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stim
        bit [PIDX_W-1:0]   loaded_q [$];
        bit                is_loaded [int];
        logic [HASH_W-1:0] inserted_q [$];
        logic [HASH_W-1:0] h;
        logic [PIDX_W-1:0] idx;
        int                cnt;
        int                r;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows
        foreach (DIR_TAB[i])
        begin
            send_item(DIR_TAB[i].act, DIR_TAB[i].hash, DIR_TAB[i].idx, DIR_TAB[i].word,
                      DIR_TAB[i].ans);
            if (DIR_TAB[i].act == ACT_LOAD && !is_loaded.exists(int'(DIR_TAB[i].idx)))
            begin
                is_loaded[int'(DIR_TAB[i].idx)] = 1'b1;
                loaded_q.push_back(DIR_TAB[i].idx);
            end
        end

        // Random phases, one word count each
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                settle();
                write_words(CFG_W'(WORDS_PLAN[ph]));
            end
            idling = (ph % 4 != 3);
            cnt = 0;
            while (cnt < PER_PHASE)
            begin
                r   = $urandom_range(0, 99);
                idx = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
                h   = rand64();
                h[PIDX_W-1:0] = idx;
                if (r < 10)
                begin
                    // load a new entry or overwrite one in use
                    if ($urandom_range(0, 1))
                        idx = PIDX_W'($urandom);
                    if (!is_loaded.exists(int'(idx)))
                    begin
                        is_loaded[int'(idx)] = 1'b1;
                        loaded_q.push_back(idx);
                    end
                    send_item(ACT_LOAD, rand64(), idx, rand_pattern(), ANS_MODEL);
                    n_load++;
                    cnt++;
                end
                else if (r < 12)
                    send_item(ACT_UNUSED, rand64(), PIDX_W'($urandom), rand64(), ANS_MODEL);
                else if (r < 45)
                begin
                    send_item(ACT_INSERT, h, PIDX_W'($urandom), rand64(), ANS_MODEL);
                    inserted_q.push_back(h);
                    if (inserted_q.size() > 200)
                        void'(inserted_q.pop_front());
                    n_insert++;
                    cnt++;
                end
                else
                begin
                    // half of the queries ask for a key inserted earlier
                    if (r < 72 && inserted_q.size() != 0)
                        h = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
                    send_item(ACT_QUERY, h, PIDX_W'($urandom), rand64(), ANS_MODEL);
                    n_query++;
                    cnt++;
                end
            end
        end
        settle();

        // every predicted result must have come out
        if (present_q.size() != 0)
            note_error($sformatf("%0d results never delivered", present_q.size()));

        $display("covered %0d loads, %0d inserts, %0d queries over %0d word counts",
                 n_load, n_insert, n_query, NUM_PHASES);
        $display("checked %0d results, %0d present, %0d errors", n_checked, n_present, err_cnt);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bbf_pkg.sv
rtl/bbf_mod_unit.sv
rtl/blocked_bloom_filter.sv
tb/sv/tb_top.sv
